[hdl/orac_pkg.sv]
// ----------------------------------------------------------------------------
// orac_pkg
// Types and constants shared by the owner range access checker.
// ----------------------------------------------------------------------------
package orac_pkg;

   localparam int ADDR_W = 64;

   // operation codes on the request channel
   localparam logic OP_ADD   = 1'b0;
   localparam logic OP_CHECK = 1'b1;

   // one protection entry
   typedef struct packed {
      logic [ADDR_W-1:0] owner_start;
      logic [ADDR_W-1:0] owner_size;
      logic [ADDR_W-1:0] region_start;
      logic [ADDR_W-1:0] region_size;
   } entry_type;

   // check token that walks the cell chain
   typedef struct packed {
      logic              valid;
      logic [ADDR_W-1:0] source_address;
      logic [ADDR_W-1:0] target_address;
      logic              hit;
      logic              granted;
   } token_type;

   // result held until the output register is free
   typedef struct packed {
      logic illegal;
      logic add_refused;
   } res_type;

endpackage

[hdl/orac_req_if.sv]
// ----------------------------------------------------------------------------
// orac_req_if
// Request channel: add a protection entry or check one access.
// ----------------------------------------------------------------------------
interface orac_req_if;
   logic                          valid;
   logic                          ready;
   logic                          operation;
   logic [orac_pkg::ADDR_W-1:0]   owner_start;
   logic [orac_pkg::ADDR_W-1:0]   owner_size;
   logic [orac_pkg::ADDR_W-1:0]   region_start;
   logic [orac_pkg::ADDR_W-1:0]   region_size;
   logic [orac_pkg::ADDR_W-1:0]   source_address;
   logic [orac_pkg::ADDR_W-1:0]   target_address;

   modport source (
      output valid, operation, owner_start, owner_size, region_start,
             region_size, source_address, target_address,
      input  ready
   );

   modport sink (
      input  valid, operation, owner_start, owner_size, region_start,
             region_size, source_address, target_address,
      output ready
   );
endinterface

[hdl/orac_rsp_if.sv]
// ----------------------------------------------------------------------------
// orac_rsp_if
// Response channel: one result per request.
// ----------------------------------------------------------------------------
interface orac_rsp_if;
   logic valid;
   logic ready;
   logic illegal;
   logic add_refused;

   modport source (
      output valid, illegal, add_refused,
      input  ready
   );

   modport sink (
      input  valid, illegal, add_refused,
      output ready
   );
endinterface

[hdl/orac_cell.sv]
// ----------------------------------------------------------------------------
// orac_cell
// One table slot: holds an entry, shifts it on add, and folds its range
// check into the passing check token.
// ----------------------------------------------------------------------------
module orac_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                shift_en,
   input  logic                active,
   input  orac_pkg::entry_type entry_in,
   output orac_pkg::entry_type entry_out,
   input  orac_pkg::token_type token_in,
   output orac_pkg::token_type token_out
);

   orac_pkg::entry_type entry_ff;
   orac_pkg::token_type token_ff;
   orac_pkg::token_type token_in_d;
   logic                data_hit;
   logic                owner_hit;

   // inclusive range, end taken without wrap
   function automatic logic covers(input logic [orac_pkg::ADDR_W-1:0] base,
                                   input logic [orac_pkg::ADDR_W-1:0] len,
                                   input logic [orac_pkg::ADDR_W-1:0] addr);
      logic [orac_pkg::ADDR_W-1:0] diff;
      diff = addr - base;
      return (addr >= base) && (diff <= len);
   endfunction

   assign data_hit  = active && covers(entry_ff.region_start, entry_ff.region_size,
                                       token_in.target_address);
   assign owner_hit = covers(entry_ff.owner_start, entry_ff.owner_size,
                             token_in.source_address);

   always_comb begin
      token_in_d         = token_in;
      token_in_d.hit     = token_in.hit | data_hit;
      token_in_d.granted = token_in.granted | (data_hit & owner_hit);
   end

   always_ff @(posedge clock) begin
      if (shift_en) begin
         entry_ff <= entry_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         token_ff.valid <= 1'b0;
      end else begin
         token_ff.valid <= token_in_d.valid;
      end
      token_ff.source_address <= token_in_d.source_address;
      token_ff.target_address <= token_in_d.target_address;
      token_ff.hit            <= token_in_d.hit;
      token_ff.granted        <= token_in_d.granted;
   end

   assign entry_out = entry_ff;
   assign token_out = token_ff;

endmodule

[hdl/owner_range_access_checker.sv]
// ----------------------------------------------------------------------------
// owner_range_access_checker
// Protection table kept in a chain of cells; checks walk the chain.
// ----------------------------------------------------------------------------
//  channel   dir  fields
//  req_if    in   operation, owner/region start+size, source/target address
//  rsp_if    out  illegal, add_refused
//
//  Add: the result passes through ST_HOLD and is then registered onto rsp_if.
//  Check: the token moves one cell per cycle through all MAX_ENTRIES cells.
//  One request in flight; req_if.ready is high only when idle, which begins
//  with the same edge that loads the result into the output register.
//  Synchronous reset clears the entry count, tokens and control; the stored
//  entries are not cleared. A stalled response holds the next result back.
// ----------------------------------------------------------------------------
module owner_range_access_checker #(
   parameter int MAX_ENTRIES = 16
) (
   input  logic        clock,
   input  logic        reset,
   orac_req_if.sink    req_if,
   orac_rsp_if.source  rsp_if
);

   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_HOLD = 3'b100
   } state_type;

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   orac_pkg::res_type    res_ff, res_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   orac_pkg::res_type    rsp_data_ff, rsp_data_in;

   orac_pkg::entry_type  entry_chain [0:MAX_ENTRIES];
   orac_pkg::token_type  token_chain [0:MAX_ENTRIES];

   logic accept;
   logic full;
   logic shift_en;
   logic slot_free;

   assign req_if.ready = (state_ff == ST_IDLE);
   assign accept       = req_if.valid && req_if.ready;
   assign full         = (count_ff == CNT_W'(MAX_ENTRIES));
   assign shift_en     = accept && (req_if.operation == orac_pkg::OP_ADD) && !full;
   assign slot_free    = !rsp_valid_ff || rsp_if.ready;

   // new entry enters at the head; older ones move down one cell
   // fields in struct order: owner start/size, region start/size
   assign entry_chain[0] = {req_if.owner_start, req_if.owner_size,
                            req_if.region_start, req_if.region_size};

   // token: valid, source, target, hit, granted
   assign token_chain[0] = {accept && (req_if.operation == orac_pkg::OP_CHECK),
                            req_if.source_address, req_if.target_address,
                            1'b0, 1'b0};

   for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_cell
      orac_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .shift_en  (shift_en),
         .active    (count_ff > CNT_W'(k)),
         .entry_in  (entry_chain[k]),
         .entry_out (entry_chain[k+1]),
         .token_in  (token_chain[k]),
         .token_out (token_chain[k+1])
      );
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_if.operation == orac_pkg::OP_ADD) begin
                  res_in.illegal     = 1'b0;
                  res_in.add_refused = full;
                  if (!full) begin
                     count_in = count_ff + CNT_W'(1);
                  end
                  state_in = ST_HOLD;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (token_chain[MAX_ENTRIES].valid) begin
               res_in.illegal     = token_chain[MAX_ENTRIES].hit &&
                                    !token_chain[MAX_ENTRIES].granted;
               res_in.add_refused = 1'b0;
               state_in           = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.illegal     = rsp_data_ff.illegal;
   assign rsp_if.add_refused = rsp_data_ff.add_refused;

endmodule

[hdl/orac_checker.sv]
// ----------------------------------------------------------------------------
// orac_checker
// Port-level checks on the owner range access checker.
// ----------------------------------------------------------------------------
module orac_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_illegal,
   input logic rsp_add_refused
);

   // held response keeps its payload until the transfer
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_illegal) &&
                                  $stable(rsp_add_refused))
      else $error("response dropped or changed while stalled");

   // one request at a time
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in flight");

   // a result comes from either an add or a check, never both
   a_res_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_illegal && rsp_add_refused))
      else $error("result flags both add and check");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind owner_range_access_checker orac_checker u_orac_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_if.valid),
   .req_ready       (req_if.ready),
   .rsp_valid       (rsp_if.valid),
   .rsp_ready       (rsp_if.ready),
   .rsp_illegal     (rsp_if.illegal),
   .rsp_add_refused (rsp_if.add_refused)
);
